FILE: src/pcsd_pkg.sv
// Shared types, codes, the AES S-box and AES helpers for the pattern CTR stream decryptor.
`default_nettype none
package pcsd_pkg;

    // Command codes of an input word.
    localparam logic CMD_READ = 1'b0;
    localparam logic CMD_SEEK = 1'b1;

    // Status codes of a result word.
    localparam logic [1:0] ST_BYTE = 2'd0;
    localparam logic [1:0] ST_END  = 2'd1;
    localparam logic [1:0] ST_SEEK = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_IV_HI  = 3'd4;
    localparam logic [2:0] REG_IV_LO  = 3'd5;
    localparam logic [2:0] REG_BASE   = 3'd6;
    localparam logic [2:0] REG_LENGTH = 3'd7;

    localparam int POS_W  = 40;
    localparam int BASE_W = 33;
    localparam int AES_ROUNDS = 14;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_OFF,
        S_CHK,
        S_AES,
        S_OUT
    } t_state;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Byte-wise S-box on a 32-bit word.
    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage
`default_nettype wire

FILE: src/pcsd_div.sv
// Divides a body position by the constant stride, one 8-bit quotient digit at a time.
`default_nettype none
module pcsd_div #(
    parameter int STRIDE = 160
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [pcsd_pkg::POS_W-1:0]  i_dividend,
    output logic                             o_done,
    output logic [pcsd_pkg::POS_W-1:0]       o_quot,
    output logic [$clog2(STRIDE)-1:0]        o_rem
);
    localparam int REM_W = $clog2(STRIDE);
    localparam int DIG_W = 8;
    localparam int V_W   = REM_W + DIG_W;
    localparam int NDIG  = pcsd_pkg::POS_W / DIG_W;
    localparam int CNT_W = $clog2(NDIG);
    // Stride reciprocal scaled by 2^V_W; the digit estimate it gives is low by at most one.
    localparam int RECIP = (1 << V_W) / STRIDE;
    localparam int RCP_W = DIG_W + 1;

    logic [pcsd_pkg::POS_W-1:0] r_q;
    logic [REM_W-1:0]           r_r;
    logic [DIG_W-1:0]           r_qd;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_phase;
    logic                       r_busy;
    logic                       r_done;
    logic [V_W-1:0]             part;
    logic [V_W+RCP_W-1:0]       prod;
    logic [V_W-1:0]             left;
    logic                       fits;
    logic                       fin;

    // Partial remainder with the next dividend digit shifted in.
    assign part = {r_r, r_q[pcsd_pkg::POS_W-1 -: DIG_W]};
    assign prod = (V_W+RCP_W)'(part) * (V_W+RCP_W)'(RECIP);
    // Remainder left by the estimated digit, and whether the digit must be raised by one.
    assign left = part - V_W'(r_qd) * V_W'(STRIDE);
    assign fits = left >= V_W'(STRIDE);
    assign fin  = r_busy && r_phase && (r_cnt == CNT_W'(NDIG - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= !i_start && fin;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= '0;
            end else if (r_busy) begin
                r_phase <= !r_phase;
                if (r_phase) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (fin) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // The first phase of a digit estimates it, the second corrects it and shifts it in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_qd <= prod[V_W +: DIG_W];
            end else begin
                r_q <= {r_q[pcsd_pkg::POS_W-DIG_W-1:0], fits ? r_qd + 1'b1 : r_qd};
                r_r <= fits ? REM_W'(left - V_W'(STRIDE)) : REM_W'(left);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule
`default_nettype wire

FILE: src/pcsd_aes.sv
// Iterative AES-256 encryptor, one round per cycle with on-the-fly key schedule.
`default_nettype none
module pcsd_aes (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [255:0] i_key,
    input  wire logic [127:0] i_block,
    output logic              o_done,
    output logic [127:0]      o_result
);
    logic [127:0] r_state;
    logic [255:0] r_kwin;
    logic [3:0]   r_round;
    logic         r_busy;
    logic         r_done;

    logic [7:0]   sb [16];
    logic [7:0]   sr [16];
    logic [7:0]   mc [16];
    logic [127:0] rnd;
    logic [31:0]  t_word;
    logic [31:0]  nk0, nk1, nk2, nk3;
    logic         last;

    assign last = r_round == 4'(pcsd_pkg::AES_ROUNDS);

    // SubBytes, ShiftRows and MixColumns of the current round.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sb[i] = pcsd_pkg::SBOX[r_state[127-8*i -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                sr[i + 4*c] = sb[i + 4*((c + i) % 4)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            mc[4*c]   = sr[4*c]   ^ (sr[4*c]^sr[4*c+1]^sr[4*c+2]^sr[4*c+3])
                        ^ pcsd_pkg::xtime(sr[4*c]   ^ sr[4*c+1]);
            mc[4*c+1] = sr[4*c+1] ^ (sr[4*c]^sr[4*c+1]^sr[4*c+2]^sr[4*c+3])
                        ^ pcsd_pkg::xtime(sr[4*c+1] ^ sr[4*c+2]);
            mc[4*c+2] = sr[4*c+2] ^ (sr[4*c]^sr[4*c+1]^sr[4*c+2]^sr[4*c+3])
                        ^ pcsd_pkg::xtime(sr[4*c+2] ^ sr[4*c+3]);
            mc[4*c+3] = sr[4*c+3] ^ (sr[4*c]^sr[4*c+1]^sr[4*c+2]^sr[4*c+3])
                        ^ pcsd_pkg::xtime(sr[4*c+3] ^ sr[4*c]);
        end
        for (int i = 0; i < 16; i++) begin
            rnd[127-8*i -: 8] = (last ? sr[i] : mc[i]) ^ r_kwin[127-8*i -: 8];
        end
    end

    // Next four key words; odd rounds produce a word index that is a multiple of eight.
    always_comb begin
        if (r_round[0]) begin
            t_word = pcsd_pkg::sub_word({r_kwin[23:0], r_kwin[31:24]})
                     ^ {8'h01 << r_round[3:1], 24'h0};
        end else begin
            t_word = pcsd_pkg::sub_word(r_kwin[31:0]);
        end
        nk0 = r_kwin[255:224] ^ t_word;
        nk1 = r_kwin[223:192] ^ nk0;
        nk2 = r_kwin[191:160] ^ nk1;
        nk3 = r_kwin[159:128] ^ nk2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Round datapath: the low half of the key window is always this round's key.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_state <= i_block ^ i_key[255:128];
            r_kwin  <= i_key;
            r_round <= 4'd1;
        end else if (r_busy) begin
            r_state <= rnd;
            r_kwin  <= {r_kwin[127:0], nk0, nk1, nk2, nk3};
            r_round <= r_round + 1'b1;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_state;
endmodule
`default_nettype wire

FILE: src/pattern_ctr_stream_decryptor.sv
// Top level of the pattern CTR stream decryptor: registers, sequencer and output word.
// One input word is taken at a time and the input stalls until its result is loaded into
// the output register. Pass-through bytes and end-of-body reads go from idle to the
// output state; a byte to decrypt passes the offset and check states and, on a cache
// miss, the AES state. Barring seeks and key or IV writes, a miss happens at most twice
// per stride. A seek runs the position divider, which estimates and corrects each 8-bit
// digit. While an output word is stalled, the sequencer stays in its output state.
`default_nettype none
module pattern_ctr_stream_decryptor #(
    parameter int PATTERN_STRIDE = 160,
    parameter int PATTERN_UNIT   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel.
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_data_in,
    input  wire logic [39:0] i_seek_position,
    // Result channel.
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_data_out,
    output logic [39:0]      o_position_out,
    output logic             o_was_encrypted,
    output logic [1:0]       o_status,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    localparam int POS_W  = pcsd_pkg::POS_W;
    localparam int REM_W  = $clog2(PATTERN_STRIDE);
    localparam int UNIT_W = $clog2(PATTERN_UNIT + 1);
    localparam int OFF_W  = POS_W + 1 + UNIT_W;
    localparam int BLK_W  = OFF_W - 4;

    pcsd_pkg::t_state r_state, n_state;

    logic [63:0] r_key [4];
    logic [63:0] r_iv_hi, r_iv_lo;
    logic [pcsd_pkg::BASE_W-1:0] r_base;
    logic [POS_W-1:0] r_length;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_quot;
    logic [REM_W-1:0] r_rem;
    logic [OFF_W-1:0] r_off;
    logic [127:0]     r_ks;
    logic [BLK_W-1:0] r_cached;
    logic             r_cache_ok;

    logic [7:0]       r_data;
    logic [7:0]       res_data;
    logic [POS_W-1:0] r_res_pos;
    logic             r_res_enc;
    logic [1:0]       r_res_st;
    logic             r_res_xor;

    logic             r_ovalid;
    logic [7:0]       r_odata;
    logic [POS_W-1:0] r_opos;
    logic             r_oenc;
    logic [1:0]       r_ost;

    logic             cfg_wr;
    logic [2:0]       cfg_idx;
    logic             cfg_flush;
    logic             accept;
    logic [POS_W-1:0] clamp;
    logic             div_start, div_done;
    logic [POS_W-1:0] div_quot;
    logic [REM_W-1:0] div_rem;
    logic             aes_start, aes_done;
    logic [127:0]     aes_out;
    logic [127:0]     counter;
    logic             out_free;
    logic [7:0]       ks_byte;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];
    assign pready  = 1'b1;
    assign accept  = i_valid && (r_state == pcsd_pkg::S_IDLE);
    assign o_stall = r_state != pcsd_pkg::S_IDLE;
    assign clamp   = (i_seek_position > r_length) ? r_length : i_seek_position;
    assign counter = {r_iv_hi, r_iv_lo} + 128'(r_off[OFF_W-1:4]);
    assign out_free = !r_ovalid || !i_stall;
    assign ks_byte = r_ks[127 - 8*r_off[3:0] -: 8];

    // A key or IV write makes the cached keystream block stale.
    assign cfg_flush = cfg_wr && (cfg_idx == pcsd_pkg::REG_KEY0
                                  || cfg_idx == pcsd_pkg::REG_KEY1
                                  || cfg_idx == pcsd_pkg::REG_KEY2
                                  || cfg_idx == pcsd_pkg::REG_KEY3
                                  || cfg_idx == pcsd_pkg::REG_IV_HI
                                  || cfg_idx == pcsd_pkg::REG_IV_LO);

    // Register file writes and reads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_key[i] <= '0;
            end
            r_iv_hi  <= '0;
            r_iv_lo  <= '0;
            r_base   <= '0;
            r_length <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                pcsd_pkg::REG_KEY0:   r_key[0] <= pwdata;
                pcsd_pkg::REG_KEY1:   r_key[1] <= pwdata;
                pcsd_pkg::REG_KEY2:   r_key[2] <= pwdata;
                pcsd_pkg::REG_KEY3:   r_key[3] <= pwdata;
                pcsd_pkg::REG_IV_HI:  r_iv_hi  <= pwdata;
                pcsd_pkg::REG_IV_LO:  r_iv_lo  <= pwdata;
                pcsd_pkg::REG_BASE:   r_base   <= pwdata[pcsd_pkg::BASE_W-1:0];
                pcsd_pkg::REG_LENGTH: r_length <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            pcsd_pkg::REG_KEY0:   prdata = r_key[0];
            pcsd_pkg::REG_KEY1:   prdata = r_key[1];
            pcsd_pkg::REG_KEY2:   prdata = r_key[2];
            pcsd_pkg::REG_KEY3:   prdata = r_key[3];
            pcsd_pkg::REG_IV_HI:  prdata = r_iv_hi;
            pcsd_pkg::REG_IV_LO:  prdata = r_iv_lo;
            pcsd_pkg::REG_BASE:   prdata = 64'(r_base);
            pcsd_pkg::REG_LENGTH: prdata = 64'(r_length);
            default:              prdata = '0;
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcsd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and unit start strobes.
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        aes_start = 1'b0;
        unique case (r_state)
            pcsd_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_cmd == pcsd_pkg::CMD_SEEK) begin
                        div_start = 1'b1;
                        n_state   = pcsd_pkg::S_DIV;
                    end else if (r_pos >= r_length
                                 || r_rem >= REM_W'(PATTERN_UNIT)) begin
                        n_state = pcsd_pkg::S_OUT;
                    end else begin
                        n_state = pcsd_pkg::S_OFF;
                    end
                end
            end
            pcsd_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = pcsd_pkg::S_OUT;
                end
            end
            pcsd_pkg::S_OFF: n_state = pcsd_pkg::S_CHK;
            pcsd_pkg::S_CHK: begin
                if (r_cache_ok && r_cached == r_off[OFF_W-1:4]) begin
                    n_state = pcsd_pkg::S_OUT;
                end else begin
                    aes_start = 1'b1;
                    n_state   = pcsd_pkg::S_AES;
                end
            end
            pcsd_pkg::S_AES: begin
                if (aes_done) begin
                    n_state = pcsd_pkg::S_OUT;
                end
            end
            pcsd_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = pcsd_pkg::S_IDLE;
                end
            end
            default: n_state = pcsd_pkg::S_IDLE;
        endcase
    end

    // Position, stride split and keystream cache.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_quot     <= '0;
            r_rem      <= '0;
            r_cache_ok <= 1'b0;
        end else begin
            if (accept && i_cmd == pcsd_pkg::CMD_SEEK) begin
                r_pos <= clamp;
            end else if (accept && r_pos < r_length) begin
                r_pos <= r_pos + 1'b1;
                if (r_rem == REM_W'(PATTERN_STRIDE - 1)) begin
                    r_rem  <= '0;
                    r_quot <= r_quot + 1'b1;
                end else begin
                    r_rem <= r_rem + 1'b1;
                end
            end else if (r_state == pcsd_pkg::S_DIV && div_done) begin
                r_quot <= div_quot;
                r_rem  <= div_rem;
            end
            if (cfg_flush || (accept && i_cmd == pcsd_pkg::CMD_SEEK)) begin
                r_cache_ok <= 1'b0;
            end else if (r_state == pcsd_pkg::S_AES && aes_done) begin
                r_cache_ok <= 1'b1;
            end
        end
    end

    // Cipher offset of the accepted byte, computed before the stride split advances.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_off <= OFF_W'(r_base) + OFF_W'(r_quot) * OFF_W'(PATTERN_UNIT)
                     + OFF_W'(r_rem);
        end
        if (r_state == pcsd_pkg::S_AES && aes_done) begin
            r_ks     <= aes_out;
            r_cached <= r_off[OFF_W-1:4];
        end
    end

    // Pending result fields latched at acceptance.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_data_in;
            if (i_cmd == pcsd_pkg::CMD_SEEK) begin
                r_res_pos <= clamp;
                r_res_enc <= 1'b0;
                r_res_st  <= pcsd_pkg::ST_SEEK;
                r_res_xor <= 1'b0;
            end else if (r_pos >= r_length) begin
                r_res_pos <= r_pos;
                r_res_enc <= 1'b0;
                r_res_st  <= pcsd_pkg::ST_END;
                r_res_xor <= 1'b0;
            end else begin
                r_res_pos <= r_pos;
                r_res_enc <= r_rem < REM_W'(PATTERN_UNIT);
                r_res_st  <= pcsd_pkg::ST_BYTE;
                r_res_xor <= r_rem < REM_W'(PATTERN_UNIT);
            end
        end
    end

    always_comb begin
        if (r_res_st != pcsd_pkg::ST_BYTE) begin
            res_data = 8'h00;
        end else if (r_res_xor) begin
            res_data = r_data ^ ks_byte;
        end else begin
            res_data = r_data;
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == pcsd_pkg::S_OUT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pcsd_pkg::S_OUT && out_free) begin
            r_odata <= res_data;
            r_opos  <= r_res_pos;
            r_oenc  <= r_res_enc;
            r_ost   <= r_res_st;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_data_out      = r_odata;
    assign o_position_out  = r_opos;
    assign o_was_encrypted = r_oenc;
    assign o_status        = r_ost;

    pcsd_div #(
        .STRIDE(PATTERN_STRIDE)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (clamp),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    pcsd_aes u_aes (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (aes_start),
        .i_key    ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_block  (counter),
        .o_done   (aes_done),
        .o_result (aes_out)
    );
endmodule
`default_nettype wire

FILE: tb/sv/pattern_ctr_stream_decryptor_tb.sv
// Self-checking testbench for the pattern CTR stream decryptor, with its own AES-256 predictor.
`default_nettype none
module pattern_ctr_stream_decryptor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data;
        logic [39:0] seek;
    } t_word_in;

    typedef struct packed {
        logic [7:0]  data;
        logic [39:0] pos;
        logic        enc;
        logic [1:0]  status;
    } t_word_out;

    localparam int STRIDE = 160;
    localparam int UNIT   = 16;
    localparam logic [39:0] LEN_MAX  = 40'hFF_FFFF_FFFF;
    localparam logic [32:0] BASE_MAX = 33'h1_FFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_cmd = pcsd_pkg::CMD_READ;
    logic [7:0]  i_data_in = '0;
    logic [39:0] i_seek_position = '0;
    logic        i_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    wire         o_stall;
    wire         o_valid;
    wire  [7:0]  o_data_out;
    wire  [39:0] o_position_out;
    wire         o_was_encrypted;
    wire  [1:0]  o_status;
    wire  [63:0] prdata;
    wire         pready;

    pattern_ctr_stream_decryptor i_dut (.*);

    // Mirror of the register file and the walk position.
    logic [63:0] key_w [4];
    logic [63:0] ctr_hi, ctr_lo;
    logic [32:0] cipher_base;
    logic [39:0] body_len;
    logic [39:0] walk_pos;
    logic [31:0] sched [60];

    t_word_in  pending_words [$];
    t_word_out plain_expected [$];
    int n_sent = 0, n_got = 0, n_errors = 0, n_enc = 0, n_end = 0, n_seek = 0;
    int hold_left = 0;
    bit long_hold_done = 0;

    initial forever #2 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] sbox_word(logic [31:0] w);
        return {pcsd_pkg::SBOX[w[31:24]], pcsd_pkg::SBOX[w[23:16]],
                pcsd_pkg::SBOX[w[15:8]], pcsd_pkg::SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] gf_double(logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // AES-256 key schedule from the mirrored key words.
    function automatic void build_schedule();
        logic [7:0]  rc [8] = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};
        logic [31:0] t;
        for (int i = 0; i < 8; i++) begin
            sched[i] = i[0] ? key_w[i >> 1][31:0] : key_w[i >> 1][63:32];
        end
        for (int i = 8; i < 60; i++) begin
            t = sched[i - 1];
            if ((i & 7) == 0) begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc[(i >> 3) & 7], 24'h0};
            end else if ((i & 7) == 4) begin
                t = sbox_word(t);
            end
            sched[i] = sched[i - 8] ^ t;
        end
    endfunction

    // One AES-256 block encryption; byte 0 is the most significant.
    function automatic logic [127:0] aes256(logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
        for (int r = 0; r <= 14; r++) begin
            if (r > 0) begin
                for (int i = 0; i < 16; i++) s[i] = pcsd_pkg::SBOX[s[i]];
                for (int c = 0; c < 4; c++)
                    for (int i = 0; i < 4; i++) t[i + 4 * c] = s[i + 4 * ((c + i) & 3)];
                s = t;
                if (r != 14) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
                        all = a0 ^ a1 ^ a2 ^ a3;
                        s[4 * c]     = a0 ^ all ^ gf_double(a0 ^ a1);
                        s[4 * c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
                        s[4 * c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
                        s[4 * c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int b = 0; b < 4; b++) s[4 * c + b] ^= sched[r * 4 + c][31 - 8 * b -: 8];
        end
        for (int i = 0; i < 16; i++) aes256[127 - 8 * i -: 8] = s[i];
    endfunction

    // Expected result of one accepted word; advances the mirrored position, or sets it on a seek.
    function automatic t_word_out decrypt_predict(t_word_in w);
        t_word_out   r;
        logic [63:0] off, rest;
        logic [127:0] pad;
        r = '0;
        if (w.cmd == pcsd_pkg::CMD_SEEK) begin
            walk_pos = (w.seek > body_len) ? body_len : w.seek;
            r.pos = walk_pos;
            r.status = pcsd_pkg::ST_SEEK;
        end else if (walk_pos >= body_len) begin
            r.pos = walk_pos;
            r.status = pcsd_pkg::ST_END;
        end else begin
            rest = 64'(walk_pos % STRIDE);
            r.pos = walk_pos;
            r.status = pcsd_pkg::ST_BYTE;
            r.data = w.data;
            if (rest < UNIT) begin
                off = 64'(cipher_base) + 64'(walk_pos / STRIDE) * UNIT + rest;
                pad = aes256({ctr_hi, ctr_lo} + {64'h0, off >> 4});
                r.data = w.data ^ pad[127 - 8 * off[3:0] -: 8];
                r.enc = 1'b1;
            end
            walk_pos = walk_pos + 40'd1;
        end
        return r;
    endfunction

    // Sender: offers words from the pending queue, idling at random.
    always @(posedge i_clk) begin
        if (i_rst_n && (!i_valid || !o_stall)) begin
            if (i_valid) begin
                plain_expected.push_back(decrypt_predict({i_cmd, i_data_in, i_seek_position}));
                n_sent++;
            end
            if (pending_words.size() > 0 &&
                ((n_sent >= 400 && n_sent < 500) || $urandom_range(99) >= 30)) begin
                t_word_in w;
                w = pending_words.pop_front();
                i_cmd <= w.cmd;
                i_data_in <= w.data;
                i_seek_position <= w.seek;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each word and stalls at random, once for a long stretch.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                t_word_out e;
                if (plain_expected.size() == 0) begin
                    $display("%0t: unexpected word pos=%h status=%0d", $time,
                             o_position_out, o_status);
                    n_errors++;
                end else begin
                    e = plain_expected.pop_front();
                    if (o_data_out !== e.data || o_position_out !== e.pos ||
                        o_was_encrypted !== e.enc || o_status !== e.status) begin
                        $display("%0t: mismatch expected data=%h pos=%h enc=%b status=%0d",
                                 $time, e.data, e.pos, e.enc, e.status);
                        $display("%0t:          actual   data=%h pos=%h enc=%b status=%0d",
                                 $time, o_data_out, o_position_out, o_was_encrypted, o_status);
                        n_errors++;
                    end
                    if (e.enc) n_enc++;
                    if (e.status == pcsd_pkg::ST_END) n_end++;
                    if (e.status == pcsd_pkg::ST_SEEK) n_seek++;
                end
                n_got++;
            end
            if (!long_hold_done && n_got == 200) begin
                long_hold_done = 1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= (n_got >= 400 && n_got < 500) ? 1'b0 : ($urandom_range(99) < 30);
            end
        end
    end

    // Register write through the configuration port; mirrors it at the write edge.
    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            pcsd_pkg::REG_KEY0, pcsd_pkg::REG_KEY1,
            pcsd_pkg::REG_KEY2, pcsd_pkg::REG_KEY3: begin
                key_w[idx] = val;
                build_schedule();
            end
            pcsd_pkg::REG_IV_HI:  ctr_hi = val;
            pcsd_pkg::REG_IV_LO:  ctr_lo = val;
            pcsd_pkg::REG_BASE:   cipher_base = val[32:0];
            pcsd_pkg::REG_LENGTH: body_len = val[39:0];
            default: ;
        endcase
    endtask

    task automatic load_all(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                            logic [63:0] k3, logic [63:0] hi, logic [63:0] lo,
                            logic [63:0] base, logic [63:0] len);
        reg_write(pcsd_pkg::REG_KEY0, k0);
        reg_write(pcsd_pkg::REG_KEY1, k1);
        reg_write(pcsd_pkg::REG_KEY2, k2);
        reg_write(pcsd_pkg::REG_KEY3, k3);
        reg_write(pcsd_pkg::REG_IV_HI, hi);
        reg_write(pcsd_pkg::REG_IV_LO, lo);
        reg_write(pcsd_pkg::REG_BASE, base);
        reg_write(pcsd_pkg::REG_LENGTH, len);
    endtask

    task automatic push_word(logic cmd, logic [7:0] data, logic [39:0] seek);
        pending_words.push_back({cmd, data, seek});
    endtask

    // Waits here until the block has answered everything, then settles.
    task automatic drain();
        while (pending_words.size() > 0 || i_valid || plain_expected.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Random words: mostly reads, seeks mostly near the interesting places.
    task automatic random_words(int count);
        logic [39:0] tgt;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 78) begin
                push_word(pcsd_pkg::CMD_READ, 8'($urandom), 40'(rand64()));
            end else begin
                case ($urandom_range(3))
                    0: tgt = 40'(rand64());
                    1: tgt = body_len - 40'($urandom_range(20));
                    2: tgt = 40'($urandom_range(2000));
                    default: tgt = 40'($urandom_range(40)) * STRIDE + $urandom_range(20);
                endcase
                push_word(pcsd_pkg::CMD_SEEK, 8'($urandom), tgt);
            end
        end
    endtask

    initial begin
        key_w = '{default: '0};
        ctr_hi = '0; ctr_lo = '0; cipher_base = '0; body_len = '0; walk_pos = '0;
        build_schedule();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty body after reset: reads end at once, a seek clamps to zero.
        push_word(pcsd_pkg::CMD_READ, 8'hFF, '0);
        push_word(pcsd_pkg::CMD_SEEK, 8'h00, LEN_MAX);
        push_word(pcsd_pkg::CMD_READ, 8'h5A, LEN_MAX);
        drain();

        // Counter about to wrap past 2^128; walk across unit and stride edges.
        load_all(rand64(), rand64(), rand64(), rand64(), '1, 64'hFFFF_FFFF_FFFF_FFF0,
                 64'd0, 64'd340);
        for (int i = 0; i < 17; i++) begin
            push_word(pcsd_pkg::CMD_READ, (i & 1) ? 8'hFF : 8'h00, '0);
        end
        push_word(pcsd_pkg::CMD_SEEK, 8'h00, 40'd159);
        push_word(pcsd_pkg::CMD_READ, 8'hA5, '0);
        push_word(pcsd_pkg::CMD_READ, 8'h3C, '0);
        push_word(pcsd_pkg::CMD_SEEK, 8'hFF, 40'd1000);
        push_word(pcsd_pkg::CMD_READ, 8'h11, '0);
        push_word(pcsd_pkg::CMD_SEEK, 8'h00, 40'd339);
        push_word(pcsd_pkg::CMD_READ, 8'h80, '0);
        push_word(pcsd_pkg::CMD_READ, 8'h01, '0);
        drain();

        // Body shortened beneath the current position.
        reg_write(pcsd_pkg::REG_LENGTH, 64'd100);
        push_word(pcsd_pkg::CMD_READ, 8'h77, '0);
        drain();

        // Random phases over several settings, extremes included.
        load_all('1, '1, '1, '1, '0, '0, 64'(BASE_MAX), 64'(LEN_MAX));
        random_words(175);
        drain();
        load_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                 rand64(), 64'($urandom_range(2000, 200)));
        random_words(175);
        drain();
        load_all('0, '0, '0, '0, '1, '1, 64'($urandom), 64'd1);
        random_words(175);
        drain();
        load_all(rand64(), rand64(), rand64(), rand64(), rand64(), '1,
                 64'(BASE_MAX) - 64'd7, 64'($urandom_range(5000, 1000)));
        random_words(175);
        drain();

        $display("Covered %0d words: %0d decrypted, %0d end-of-body, %0d seeks.",
                 n_got, n_enc, n_end, n_seek);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire
